// ===== sv/bba_pkg.sv =====
`timescale 1ns / 1ps
// package for the buddy address allocator: sizes, codes, payload types and
// node helpers; no dependencies
package bba_pkg;

    localparam int ADDR_BITS      = 32;
    localparam int MIN_BLOCK_BITS = 20;
    localparam int TREE_LEVELS    = ADDR_BITS - MIN_BLOCK_BITS;
    localparam int NODE_COUNT     = (2 << TREE_LEVELS) - 1;
    localparam int IDX_W          = TREE_LEVELS + 1;
    localparam int DEPTH_W        = $clog2(TREE_LEVELS + 2);
    localparam int SIZE_W         = ADDR_BITS + 2;
    localparam int CODE_W         = 5;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NO_SPACE  = 2'd1,
        STS_NOT_ALLOC = 2'd2,
        STS_ZERO_SIZE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        FSM_IDLE,
        FSM_ROOT,
        FSM_VISIT,
        FSM_KIDS,
        FSM_FCHILD,
        FSM_CLR_L,
        FSM_CLR_R,
        FSM_UP_RD,
        FSM_UP_WAIT,
        FSM_DONE
    } fsm_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [32:0] request_bytes;
        logic [31:0] address;
    } in_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] block_address;
        logic [32:0] block_bytes;
        logic        found;
    } out_t;

    typedef struct packed {
        logic              split;
        logic              alloc;
        logic [CODE_W-1:0] code;
    } entry_t;

    typedef logic [IDX_W-1:0] node_idx_t;

    typedef struct packed {
        logic      rd_en;
        node_idx_t rd_addr_a;
        node_idx_t rd_addr_b;
        logic      wr_en;
        node_idx_t wr_addr;
        entry_t    wr_data;
    } mem_req_t;

    function automatic logic [SIZE_W-1:0] level_bytes(input logic [DEPTH_W-1:0] d);
        return SIZE_W'(1) << (ADDR_BITS - int'(d));
    endfunction

    function automatic logic [SIZE_W-1:0] code_bytes(input logic [CODE_W-1:0] c);
        if (c == '0) begin
            return '0;
        end
        return SIZE_W'(1) << (ADDR_BITS + 1 - int'(c));
    endfunction

    // free size of a node as a size code, 0 when nothing is free
    function automatic logic [CODE_W-1:0] free_code(input entry_t e,
                                                    input logic [DEPTH_W-1:0] d);
        if (e.split && (int'(d) < TREE_LEVELS)) begin
            if (e.code != '0 && int'(e.code) <= TREE_LEVELS + 1) begin
                return e.code;
            end
            return '0;
        end
        if (e.alloc) begin
            return '0;
        end
        return CODE_W'(d) + CODE_W'(1);
    endfunction

    function automatic entry_t refresh_entry(input entry_t a, input entry_t b,
                                             input logic [DEPTH_W-1:0] d);
        logic [CODE_W-1:0] ca;
        logic [CODE_W-1:0] cb;
        entry_t            e;
        ca = free_code(a, d);
        cb = free_code(b, d);
        e.split = 1'b1;
        e.alloc = 1'b1;
        e.code  = (code_bytes(ca) >= code_bytes(cb)) ? ca : cb;
        return e;
    endfunction

    function automatic node_idx_t left_child(input node_idx_t i);
        return {i[IDX_W-2:0], 1'b0} + IDX_W'(1);
    endfunction

    function automatic node_idx_t parent_of(input node_idx_t i);
        node_idx_t t;
        t = i - IDX_W'(1);
        return t >> 1;
    endfunction

endpackage

// ===== sv/bba_node_store.sv =====
`timescale 1ns / 1ps
// node memory of the allocator tree: one write port, two registered read ports
// depends on bba_pkg; the root reads as a free unsplit leaf until first written
module bba_node_store (
    input  logic              aclk,
    input  logic              aresetn,
    input  bba_pkg::mem_req_t req,
    output bba_pkg::entry_t   rdata_a,
    output bba_pkg::entry_t   rdata_b
);
    import bba_pkg::*;

    entry_t    mem [NODE_COUNT];
    entry_t    q_a_reg;
    entry_t    q_b_reg;
    node_idx_t raddr_a_reg;
    node_idx_t raddr_b_reg;
    logic      root_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            q_a_reg     <= mem[req.rd_addr_a];
            q_b_reg     <= mem[req.rd_addr_b];
            raddr_a_reg <= req.rd_addr_a;
            raddr_b_reg <= req.rd_addr_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_valid_reg <= 1'b0;
        end else if (req.wr_en && req.wr_addr == '0) begin
            root_valid_reg <= 1'b1;
        end
    end

    assign rdata_a = (raddr_a_reg == '0 && !root_valid_reg) ? '0 : q_a_reg;
    assign rdata_b = (raddr_b_reg == '0 && !root_valid_reg) ? '0 : q_b_reg;

endmodule

// ===== sv/bba_ctrl.sv =====
`timescale 1ns / 1ps
// walk sequencer: descends and climbs the node tree, at most one memory access per step
// depends on bba_pkg; drives the node store and hands finished results upward
module bba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bba_pkg::in_t      s_data,
    output logic              res_push,
    input  logic              res_ready,
    output bba_pkg::out_t     res_data,
    output bba_pkg::mem_req_t mem_req,
    input  bba_pkg::entry_t   rdata_a,
    input  bba_pkg::entry_t   rdata_b
);
    import bba_pkg::*;

    localparam logic [SIZE_W-1:0] ROUND_MASK = SIZE_W'((64'd1 << MIN_BLOCK_BITS) - 64'd1);

    fsm_t                state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [SIZE_W-1:0]   req_reg, req_next;
    logic [31:0]         addr_reg, addr_next;
    node_idx_t           node_reg, node_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [31:0]         base_reg, base_next;
    entry_t              cur_reg, cur_next;
    out_t                res_reg, res_next;

    node_idx_t           left_idx;
    logic [DEPTH_W-1:0]  depth_inc;
    logic [SIZE_W-1:0]   half_bytes;
    logic [SIZE_W-1:0]   le_bytes;
    logic [SIZE_W-1:0]   re_bytes;
    logic                go_right;
    logic                is_split;
    logic [SIZE_W-1:0]   mid_addr;
    logic [SIZE_W-1:0]   node_bytes;
    logic [SIZE_W-1:0]   node_end;

    assign left_idx   = left_child(node_reg);
    assign depth_inc  = depth_reg + DEPTH_W'(1);
    assign half_bytes = level_bytes(depth_inc);
    assign le_bytes   = code_bytes(free_code(rdata_a, depth_inc));
    assign re_bytes   = code_bytes(free_code(rdata_b, depth_inc));
    assign go_right   = (le_bytes < req_reg) || ((le_bytes > re_bytes) && (re_bytes >= req_reg));
    assign is_split   = cur_reg.split && (int'(depth_reg) < TREE_LEVELS);
    assign mid_addr   = SIZE_W'(base_reg) + half_bytes;
    assign node_bytes = level_bytes(depth_reg);
    assign node_end   = SIZE_W'(base_reg) + node_bytes;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cmd_reg   <= cmd_next;
        req_reg   <= req_next;
        addr_reg  <= addr_next;
        node_reg  <= node_next;
        depth_reg <= depth_next;
        base_reg  <= base_next;
        cur_reg   <= cur_next;
        res_reg   <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        req_next   = req_reg;
        addr_next  = addr_reg;
        node_next  = node_reg;
        depth_next = depth_reg;
        base_next  = base_reg;
        cur_next   = cur_reg;
        res_next   = res_reg;
        mem_req    = '0;
        s_ready    = 1'b0;
        res_push   = 1'b0;

        unique case (state_reg)
            FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next   = s_data.cmd;
                    // round up to a whole number of minimum blocks
                    req_next   = (SIZE_W'(s_data.request_bytes) + ROUND_MASK) & ~ROUND_MASK;
                    addr_next  = s_data.address;
                    node_next  = '0;
                    depth_next = '0;
                    base_next  = '0;
                    res_next   = '0;
                    mem_req.rd_en     = 1'b1;
                    mem_req.rd_addr_a = '0;
                    state_next = FSM_ROOT;
                end
            end
            FSM_ROOT: begin
                cur_next   = rdata_a;
                state_next = FSM_VISIT;
                unique case (cmd_reg)
                    CMD_NONE: begin
                        state_next = FSM_DONE;
                    end
                    CMD_ALLOC: begin
                        if (req_reg == '0) begin
                            res_next.status = STS_ZERO_SIZE;
                            state_next      = FSM_DONE;
                        end else if (code_bytes(free_code(rdata_a, '0)) < req_reg) begin
                            res_next.status = STS_NO_SPACE;
                            state_next      = FSM_DONE;
                        end
                    end
                    CMD_FREE, CMD_CHECK: begin
                        state_next = FSM_VISIT;
                    end
                endcase
            end
            FSM_VISIT: begin
                if (cmd_reg == CMD_ALLOC) begin
                    if (is_split) begin
                        mem_req.rd_en     = 1'b1;
                        mem_req.rd_addr_a = left_idx;
                        mem_req.rd_addr_b = left_idx + IDX_W'(1);
                        state_next        = FSM_KIDS;
                    end else if (int'(depth_reg) < TREE_LEVELS && half_bytes > req_reg) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = node_reg;
                        mem_req.wr_data = '{split: 1'b1, alloc: 1'b1, code: '0};
                        state_next      = FSM_CLR_L;
                    end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = node_reg;
                        mem_req.wr_data = '{split: 1'b0, alloc: 1'b1, code: '0};
                        res_next.block_address = base_reg;
                        res_next.block_bytes   = node_bytes[32:0];
                        state_next = (depth_reg == '0) ? FSM_DONE : FSM_UP_RD;
                    end
                end else if (is_split) begin
                    mem_req.rd_en = 1'b1;
                    if ({2'b00, addr_reg} >= mid_addr) begin
                        mem_req.rd_addr_a = left_idx + IDX_W'(1);
                        node_next         = left_idx + IDX_W'(1);
                        base_next         = mid_addr[31:0];
                    end else begin
                        mem_req.rd_addr_a = left_idx;
                        node_next         = left_idx;
                    end
                    depth_next = depth_inc;
                    state_next = FSM_FCHILD;
                end else if (cmd_reg == CMD_CHECK) begin
                    res_next.found = cur_reg.alloc && ({2'b00, addr_reg} < node_end);
                    state_next     = FSM_DONE;
                end else if (!cur_reg.alloc || base_reg != addr_reg) begin
                    res_next.status = STS_NOT_ALLOC;
                    state_next      = FSM_DONE;
                end else begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = node_reg;
                    mem_req.wr_data = '0;
                    res_next.block_bytes = node_bytes[32:0];
                    state_next = (depth_reg == '0) ? FSM_DONE : FSM_UP_RD;
                end
            end
            FSM_KIDS: begin
                if (go_right) begin
                    node_next = left_idx + IDX_W'(1);
                    cur_next  = rdata_b;
                    base_next = mid_addr[31:0];
                end else begin
                    node_next = left_idx;
                    cur_next  = rdata_a;
                end
                depth_next = depth_inc;
                state_next = FSM_VISIT;
            end
            FSM_FCHILD: begin
                cur_next   = rdata_a;
                state_next = FSM_VISIT;
            end
            FSM_CLR_L: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = left_idx;
                mem_req.wr_data = '0;
                state_next      = FSM_CLR_R;
            end
            FSM_CLR_R: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = left_idx + IDX_W'(1);
                mem_req.wr_data = '0;
                node_next       = left_idx;
                depth_next      = depth_inc;
                cur_next        = '0;
                state_next      = FSM_VISIT;
            end
            FSM_UP_RD: begin
                mem_req.rd_en     = 1'b1;
                mem_req.rd_addr_a = left_child(parent_of(node_reg));
                mem_req.rd_addr_b = left_child(parent_of(node_reg)) + IDX_W'(1);
                node_next         = parent_of(node_reg);
                depth_next        = depth_reg - DEPTH_W'(1);
                state_next        = FSM_UP_WAIT;
            end
            FSM_UP_WAIT: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = node_reg;
                // buddies both free on release: collapse into one free leaf
                if (cmd_reg == CMD_FREE && !rdata_a.alloc && !rdata_b.alloc) begin
                    mem_req.wr_data = '0;
                end else begin
                    mem_req.wr_data = refresh_entry(rdata_a, rdata_b, depth_inc);
                end
                state_next = (depth_reg == '0) ? FSM_DONE : FSM_UP_RD;
            end
            FSM_DONE: begin
                if (res_ready) begin
                    res_push   = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign res_data = res_reg;

`ifndef SYNTH
    a_depth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != FSM_IDLE) |-> (int'(depth_reg) <= TREE_LEVELS))
        else $error("walk depth beyond leaf level");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.wr_en && mem_req.rd_en &&
          (mem_req.wr_addr == mem_req.rd_addr_a || mem_req.wr_addr == mem_req.rd_addr_b)))
        else $error("node read and write to the same entry in one cycle");

    a_push_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |=> (state_reg == FSM_IDLE))
        else $error("sequencer not idle after result hand-off");

    a_depth_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_KIDS || state_reg == FSM_CLR_R) |=>
            (depth_reg == $past(depth_reg) + DEPTH_W'(1)))
        else $error("descent skipped a level");
`endif

endmodule

// ===== sv/buddy_address_allocator.sv =====
`timescale 1ns / 1ps
// Binary buddy allocator over a 4 GiB space with 1 MiB minimum blocks, held
// as a node tree twelve levels deep in one on-chip memory. One transaction
// is worked at a time: a request reads the root, then descends a level at a
// time (splitting a free leaf and clearing both its children where needed),
// visits the final node, climbs back up rewriting each parent, and hands
// over the result. Every step makes at most one access to the node memory.
// A new transaction is taken while the previous result waits on the output
// register. After reset the whole space is one free block.
// depends on bba_pkg, bba_node_store and bba_ctrl
module buddy_address_allocator (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bba_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output bba_pkg::out_t m_data
);
    import bba_pkg::*;

    mem_req_t mem_req;
    entry_t   rdata_a;
    entry_t   rdata_b;
    logic     res_push;
    logic     res_ready;
    out_t     res_data;
    logic     m_valid_reg;
    out_t     m_data_reg;

    assign res_ready = !m_valid_reg || m_ready;

    bba_node_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    bba_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res_push  (res_push),
        .res_ready (res_ready),
        .res_data  (res_data),
        .mem_req   (mem_req),
        .rdata_a   (rdata_a),
        .rdata_b   (rdata_b)
    );

    // output register holding one finished transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_push) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== tb/buddy_address_allocator_checker.sv =====
`timescale 1ns / 1ps
// result checker for the buddy address allocator: watches both channels,
// keeps its own node tree and compares every result; depends on bba_pkg
module buddy_address_allocator_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  bba_pkg::in_t  s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  bba_pkg::out_t m_data,
    output int            fail_count,
    output int            pending_count
);
    import bba_pkg::*;

    localparam int LEVELS = TREE_LEVELS;
    localparam int NODES  = NODE_COUNT;

    logic [6:0]  tree_nodes [NODES];
    out_t        expected_results [$];

    assign pending_count = expected_results.size();

    function automatic logic [63:0] span_of(input int d);
        return 64'd1 << (ADDR_BITS - d);
    endfunction

    function automatic logic [63:0] bytes_of_code(input logic [6:0] n);
        int v;
        v = n[4:0];
        if (v == 0 || v - 1 > LEVELS) return 64'd0;
        return span_of(v - 1);
    endfunction

    function automatic logic [4:0] code_of_bytes(input logic [63:0] b);
        for (int d = 0; d <= LEVELS; d++)
            if (span_of(d) == b) return 5'(d + 1);
        return 5'd0;
    endfunction

    function automatic bit node_split(input int i, input int d);
        return tree_nodes[i][6] && d < LEVELS;
    endfunction

    function automatic logic [63:0] node_free(input int i, input int d);
        if (node_split(i, d)) return bytes_of_code(tree_nodes[i]);
        if (tree_nodes[i][5]) return 64'd0;
        return span_of(d);
    endfunction

    function automatic void recompute(input int j, input int k);
        logic [63:0] a, b;
        a = node_free(2 * j + 1, k + 1);
        b = node_free(2 * j + 2, k + 1);
        tree_nodes[j] = {2'b11, code_of_bytes(a > b ? a : b)};
    endfunction

    function automatic out_t predict_result(input in_t t);
        out_t        r;
        int          path [LEVELS + 1];
        int          i, d, l;
        logic [63:0] req, base, le, re, addr, sz;
        r = '0;
        i = 0; d = 0; base = 0;
        addr = {32'd0, t.address};
        if (t.cmd == CMD_NONE) return r;
        if (t.cmd == CMD_ALLOC) begin
            req = {31'd0, t.request_bytes};
            if (req == 0) begin r.status = STS_ZERO_SIZE; return r; end
            req = (req + (64'd1 << MIN_BLOCK_BITS) - 1) & ~((64'd1 << MIN_BLOCK_BITS) - 1);
            if (node_free(0, 0) < req) begin r.status = STS_NO_SPACE; return r; end
            forever begin
                path[d] = i;
                if (node_split(i, d)) begin
                    l = 2 * i + 1;
                    le = node_free(l, d + 1);
                    re = node_free(l + 1, d + 1);
                    if (le < req || (le > re && re >= req)) begin
                        base += span_of(d + 1);
                        i = l + 1;
                    end else begin
                        i = l;
                    end
                    d++;
                end else if (d < LEVELS && (span_of(d) >> 1) > req) begin
                    tree_nodes[i] = 7'h60;
                    tree_nodes[2 * i + 1] = 0;
                    tree_nodes[2 * i + 2] = 0;
                    i = 2 * i + 1;
                    d++;
                end else begin
                    tree_nodes[i] = 7'h20;
                    break;
                end
            end
            for (int k = d - 1; k >= 0; k--) recompute(path[k], k);
            r.block_address = base[31:0];
            sz = span_of(d);
            r.block_bytes = sz[32:0];
            return r;
        end
        forever begin
            path[d] = i;
            if (!node_split(i, d)) break;
            if (addr >= base + span_of(d + 1)) begin
                base += span_of(d + 1);
                i = 2 * i + 2;
            end else begin
                i = 2 * i + 1;
            end
            d++;
        end
        if (t.cmd == CMD_CHECK) begin
            r.found = tree_nodes[i][5] && base <= addr && addr < base + span_of(d);
            return r;
        end
        if (!tree_nodes[i][5] || base != addr) begin
            r.status = STS_NOT_ALLOC;
            return r;
        end
        tree_nodes[i] = 0;
        sz = span_of(d);
        r.block_bytes = sz[32:0];
        for (int k = d - 1; k >= 0; k--) begin
            if (!tree_nodes[2 * path[k] + 1][5] && !tree_nodes[2 * path[k] + 2][5])
                tree_nodes[path[k]] = 0;
            else
                recompute(path[k], k);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input out_t got, input out_t want);
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        foreach (tree_nodes[n]) tree_nodes[n] = 0;
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) expected_results.push_back(predict_result(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_data, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", m_data, want);
                    else if (m_data.block_address !== want.block_address)
                        report_mismatch("block_address", m_data, want);
                    else if (m_data.block_bytes !== want.block_bytes)
                        report_mismatch("block_bytes", m_data, want);
                    else if (m_data.found !== want.found)
                        report_mismatch("found", m_data, want);
                end
            end
        end
    end
endmodule

// ===== tb/buddy_address_allocator_test.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the buddy address allocator: allocate, free and
// check traffic with random idling; depends on bba_pkg and the checker
module buddy_address_allocator_test;
    import bba_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 1000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;
    bit   quiet_phase = 1'b0;
    logic [31:0] live_blocks [$];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    buddy_address_allocator u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    buddy_address_allocator_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // remember granted blocks so frees mostly hit real allocations
    always @(posedge aclk) begin
        if (m_valid && m_ready && m_data.status == STS_OK && m_data.block_bytes != 0
            && live_blocks.size() < 64 && $urandom_range(0, 1) == 0)
            live_blocks.push_back(m_data.block_address);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("buddy_address_allocator: mismatch");
            $finish;
        end
    end

    // result side stalls in bursts
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 10);
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic send_item(input cmd_t c, input logic [32:0] req, input logic [31:0] addr);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{cmd: c, request_bytes: req, address: addr};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [32:0] random_request();
        int p;
        p = $urandom_range(0, 9);
        if (p < 6) return 33'($urandom_range(1, 33'd1 << $urandom_range(20, 26)));
        if (p < 8) return 33'(1) << $urandom_range(18, 28);
        return {1'($urandom), $urandom};
    endfunction

    initial begin
        int   pick;
        logic [31:0] a;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: zero size, whole space, oversize, minimum, odd sizes
        send_item(CMD_CHECK, '0, 32'h0);
        send_item(CMD_ALLOC, '0, 32'hFFFF_FFFF);
        send_item(CMD_ALLOC, 33'h1_FFFF_FFFF, '0);
        send_item(CMD_ALLOC, 33'h1_0000_0000, '0);
        send_item(CMD_CHECK, '0, 32'hFFFF_FFFF);
        send_item(CMD_ALLOC, 33'd1, '0);
        send_item(CMD_FREE, '0, 32'h0);
        send_item(CMD_FREE, '0, 32'h0);
        send_item(CMD_ALLOC, 33'd1, '0);
        send_item(CMD_ALLOC, 33'h10_0001, '0);
        send_item(CMD_ALLOC, 33'h8000_0000, '0);
        send_item(CMD_ALLOC, 33'h8000_0001, '0);
        send_item(CMD_CHECK, '0, 32'h0010_0000);
        send_item(CMD_CHECK, '0, 32'h7FFF_FFFF);
        send_item(CMD_FREE, '0, 32'h0010_0000);
        send_item(CMD_FREE, '0, 32'h1234_5678);
        send_item(CMD_NONE, 33'h1_FFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_FREE, '0, 32'h0);
        send_item(CMD_FREE, '0, 32'h8000_0000);
        send_item(CMD_FREE, '0, 32'h0030_0000);
        send_item(CMD_FREE, '0, 32'h0020_0000);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n > RANDOM_ITEMS * 9 / 10) quiet_phase = 1'b1;
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                send_item(CMD_ALLOC, random_request(), $urandom);
            end else if (pick < 13 && live_blocks.size() > 0) begin
                a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                foreach (live_blocks[k]) if (live_blocks[k] == a) begin
                    live_blocks.delete(k);
                    break;
                end
                send_item(CMD_FREE, 33'($urandom), a);
            end else if (pick < 17) begin
                send_item(CMD_CHECK, {1'($urandom), $urandom}, $urandom);
            end else if (pick < 19) begin
                send_item(CMD_FREE, {1'($urandom), $urandom},
                          $urandom_range(0, 1) ? $urandom : ($urandom & 32'hFFF0_0000));
            end else begin
                send_item(CMD_NONE, {1'($urandom), $urandom}, $urandom);
            end
        end
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("buddy_address_allocator: match");
        end else begin
            $display("buddy_address_allocator: mismatch");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/bba_pkg.sv
sv/bba_node_store.sv
sv/bba_ctrl.sv
sv/buddy_address_allocator.sv
tb/buddy_address_allocator_checker.sv
tb/buddy_address_allocator_test.sv
